// File: design/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;

  // Data and arithmetic widths: compares need headroom above 32-bit addresses
  localparam int DW = 32;
  localparam int CW = 35;
  localparam int CFG_IDX_W = 8;

  // Size rounding constants
  localparam logic [CW-1:0] ALIGN_LSB  = CW'(7);
  localparam logic [CW-1:0] ROUND_MASK = ~CW'(7);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_A_CHK, S_A_FIRST, S_A_SCRD, S_A_SCCK, S_A_GROW,
    S_INS_RD, S_INS_MV, S_INS_WR, S_FIND_RD, S_FIND_CK, S_HIT,
    S_REM_RD, S_REM_MV, S_RS_NXCK, S_DONE
  } st_t;

  typedef enum logic [1:0] {K_ALLOC, K_FREE, K_RESIZE, K_MOVE} kind_t;

  typedef enum logic [1:0] {RA_IDX, RA_DEC, RA_INC} ra_t;
  typedef enum logic [1:0] {WA_IDX, WA_DEC, WA_POS} wa_t;
  typedef enum logic [1:0] {WD_RDQ, WD_NEW, WD_RESIZE} wd_t;
  typedef enum logic [2:0] {IX_HOLD, IX_ZERO, IX_ONE, IX_COUNT, IX_INC, IX_DEC} ix_t;
  typedef enum logic [1:0] {INS_HOLD, INS_BASE, INS_GAP, INS_TOP} ins_t;
  typedef enum logic [2:0] {TOP_HOLD, TOP_GROW, TOP_CUR, TOP_PREV, TOP_RESIZE} top_t;
  typedef enum logic [2:0] {
    RES_HOLD, RES_CLR, RES_ALLOC, RES_INPLACE, RES_FREE, RES_MOVE, RES_SAVECP
  } res_t;

  typedef struct packed {
    logic [DW-1:0] start;
    logic [DW-1:0] pay;
  } ent_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic rd;
    ra_t  ra;
    logic wr;
    wa_t  wa;
    wd_t  wd;
    ix_t  ix;
    logic prev_ld;
    logic cur_ld;
    ins_t ins;
    logic cnt_inc;
    logic cnt_dec;
    top_t top;
    res_t res;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic addr_zero;
    logic req_zero;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_one;
    logic idx_at_cnt;
    logic idx_at_pos;
    logic idx_last;
    logic first_ok;
    logic gap_ok;
    logic match;
    logic grow_ok;
    logic shrink_ok;
    logic last_ok;
    logic next_ok;
  } sts_t;

endpackage

// File: design/ffa_req_if.sv
`timescale 1ns / 1ps
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] block_address;
  logic [31:0] request_size;
  modport source (output valid, operation, block_address, request_size, input ready);
  modport sink (input valid, operation, block_address, request_size, output ready);
endinterface

// File: design/ffa_rsp_if.sv
`timescale 1ns / 1ps
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic        success;
  logic        must_copy;
  logic [31:0] copy_length;
  modport source (output valid, result_address, success, must_copy, copy_length,
                  input ready);
  modport sink (input valid, result_address, success, must_copy, copy_length,
                output ready);
endinterface

// File: design/ffa_cfg_if.sv
`timescale 1ns / 1ps
interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/ffa_dp.sv
`timescale 1ns / 1ps
module ffa_dp #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ffa_pkg::cmd_t                     cmd,
  output ffa_pkg::sts_t                     sts,
  input  logic [1:0]                        in_operation,
  input  logic [ffa_pkg::DW-1:0]            in_block_address,
  input  logic [ffa_pkg::DW-1:0]            in_request_size,
  input  logic                              cfg_valid,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffa_pkg::DW-1:0]            cfg_data,
  output logic [ffa_pkg::DW-1:0]            result_address,
  output logic                              success,
  output logic                              must_copy,
  output logic [ffa_pkg::DW-1:0]            copy_length
);
  import ffa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
  localparam logic [DW-1:0] AMASK =
    (ADDR_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << ADDR_BITS) - 64'd1);

  ent_t            mem [MAX_BLOCKS];
  ent_t            rdq_r;
  logic [1:0]      op_r;
  logic [DW-1:0]   addr_r;
  logic            req_zero_r;
  logic [CW-1:0]   size_r;
  logic [DW-1:0]   base_r, limit_r, top_r;
  logic [NW-1:0]   count_r, idx_r, ins_pos_r;
  logic [DW-1:0]   cur_start_r, cur_pay_r, ins_start_r;
  logic [CW-1:0]   prev_end_r;
  logic [DW-1:0]   res_addr_r, res_cp_r;
  logic            res_ok_r, res_mv_r;
  logic [NW-1:0]   ra_full, wa_full;
  ent_t            wd;
  logic [DW-1:0]   new_pay;

  // Select memory addresses and write data
  always_comb begin
    case (cmd.ra)
      RA_DEC:  ra_full = idx_r - NW'(1);
      RA_INC:  ra_full = idx_r + NW'(1);
      default: ra_full = idx_r;
    endcase
    case (cmd.wa)
      WA_DEC:  wa_full = idx_r - NW'(1);
      WA_POS:  wa_full = ins_pos_r;
      default: wa_full = idx_r;
    endcase
    new_pay = DW'(size_r - HDR);
    case (cmd.wd)
      WD_NEW:    wd = '{start: ins_start_r, pay: new_pay};
      WD_RESIZE: wd = '{start: cur_start_r, pay: new_pay};
      default:   wd = rdq_r;
    endcase
  end

  // Block table memory
  always_ff @(posedge clk) begin
    if (cmd.rd) rdq_r <= mem[ra_full[IW-1:0]];
    if (cmd.wr) mem[wa_full[IW-1:0]] <= wd;
  end

  // Status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.addr_zero  = (addr_r == '0);
    sts.req_zero   = req_zero_r;
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = (count_r == NW'(MAX_BLOCKS));
    sts.cnt_one    = (count_r == NW'(1));
    sts.idx_at_cnt = (idx_r == count_r);
    sts.idx_at_pos = (idx_r == ins_pos_r);
    sts.idx_last   = ((idx_r + NW'(1)) == count_r);
    sts.first_ok   = (CW'(base_r) + size_r) < CW'(rdq_r.start);
    sts.gap_ok     = CW'(rdq_r.start) >= (prev_end_r + size_r);
    sts.match      = (CW'(rdq_r.start) + HDR) == CW'(addr_r);
    sts.grow_ok    = (CW'(top_r) + size_r) <= CW'(limit_r);
    sts.shrink_ok  = (CW'(cur_pay_r) + HDR) >= size_r;
    sts.last_ok    = (CW'(cur_start_r) + size_r) <= CW'(limit_r);
    sts.next_ok    = (rdq_r.start < cur_start_r) ||
                     (CW'(rdq_r.start) > (CW'(cur_start_r) + size_r));
  end

  // Latch the request and keep the scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_operation;
      addr_r     <= in_block_address;
      req_zero_r <= (in_request_size == '0);
      size_r     <= (CW'(in_request_size) + HDR + ALIGN_LSB) & ROUND_MASK;
    end
    if (cmd.prev_ld) prev_end_r <= CW'(rdq_r.start) + HDR + CW'(rdq_r.pay);
    if (cmd.cur_ld) begin
      cur_start_r <= rdq_r.start;
      cur_pay_r   <= rdq_r.pay;
    end
    case (cmd.ins)
      INS_BASE: begin
        ins_start_r <= base_r;
        ins_pos_r   <= '0;
      end
      INS_GAP: begin
        ins_start_r <= DW'(prev_end_r);
        ins_pos_r   <= idx_r;
      end
      INS_TOP: begin
        ins_start_r <= top_r;
        ins_pos_r   <= count_r;
      end
      default: ;
    endcase
  end

  // Result registers, shown on the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_addr_r <= '0;
      res_ok_r   <= 1'b0;
      res_mv_r   <= 1'b0;
      res_cp_r   <= '0;
    end else begin
      case (cmd.res)
        RES_CLR: begin
          res_addr_r <= '0;
          res_ok_r   <= 1'b0;
          res_mv_r   <= 1'b0;
          res_cp_r   <= '0;
        end
        RES_ALLOC: begin
          res_addr_r <= DW'(CW'(ins_start_r) + HDR) & AMASK;
          res_ok_r   <= 1'b1;
        end
        RES_INPLACE: begin
          res_addr_r <= addr_r & AMASK;
          res_ok_r   <= 1'b1;
        end
        RES_FREE: begin
          res_addr_r <= '0;
          res_ok_r   <= 1'b1;
        end
        RES_MOVE:   res_mv_r <= 1'b1;
        RES_SAVECP: res_cp_r <= cur_pay_r;
        default: ;
      endcase
    end
  end

  // Control state: index, count, heap top and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
      base_r  <= '0;
      limit_r <= DW'(65536);
      top_r   <= '0;
    end else begin
      case (cmd.ix)
        IX_ZERO:  idx_r <= '0;
        IX_ONE:   idx_r <= NW'(1);
        IX_COUNT: idx_r <= count_r;
        IX_INC:   idx_r <= idx_r + NW'(1);
        IX_DEC:   idx_r <= idx_r - NW'(1);
        default: ;
      endcase
      if (cmd.cnt_inc) count_r <= count_r + NW'(1);
      else if (cmd.cnt_dec) count_r <= count_r - NW'(1);
      case (cmd.top)
        TOP_GROW:   top_r <= DW'(CW'(top_r) + size_r);
        TOP_CUR:    top_r <= cur_start_r;
        TOP_PREV:   top_r <= DW'(prev_end_r);
        TOP_RESIZE: top_r <= DW'(CW'(cur_start_r) + size_r);
        default: ;
      endcase
      if (cfg_valid) begin
        if (cfg_index == REG_HEAP_BASE) begin
          base_r <= cfg_data;
          if (count_r == '0) top_r <= cfg_data;
        end else if (cfg_index == REG_HEAP_LIMIT) begin
          limit_r <= cfg_data;
        end
      end
    end
  end

  assign result_address = res_addr_r;
  assign success        = res_ok_r;
  assign must_copy      = res_mv_r;
  assign copy_length    = res_cp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_BLOCKS))
    else $error("block count above table depth");
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> wa_full <= count_r)
    else $error("table write beyond live entries");
  a_base_moves_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == REG_HEAP_BASE && count_r == '0) |=> top_r == base_r)
    else $error("heap top not following base on empty table");

endmodule

// File: design/ffa_ctrl.sv
`timescale 1ns / 1ps
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);
  import ffa_pkg::*;

  st_t   st_r, st_nxt;
  kind_t kind_r, kind_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  accept;

  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      kind_r      <= K_ALLOC;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (st_r)
      S_IDLE: if (accept) st_nxt = S_DISP;
      S_DISP: begin
        if (sts.op == OP_ALLOC) begin
          kind_nxt = K_ALLOC;
          st_nxt   = S_A_CHK;
        end else if (sts.op == OP_FREE) begin
          kind_nxt = K_FREE;
          st_nxt   = sts.addr_zero ? S_DONE : S_FIND_RD;
        end else if (sts.op == OP_RESIZE) begin
          if (sts.addr_zero) begin
            kind_nxt = K_ALLOC;
            st_nxt   = S_A_CHK;
          end else begin
            kind_nxt = sts.req_zero ? K_FREE : K_RESIZE;
            st_nxt   = S_FIND_RD;
          end
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_A_CHK: begin
        if (sts.cnt_full) st_nxt = S_DONE;
        else if (sts.cnt_zero) st_nxt = S_A_GROW;
        else st_nxt = S_A_FIRST;
      end
      S_A_FIRST: begin
        if (sts.first_ok) st_nxt = S_INS_RD;
        else if (sts.cnt_one) st_nxt = S_A_GROW;
        else st_nxt = S_A_SCRD;
      end
      S_A_SCRD: st_nxt = S_A_SCCK;
      S_A_SCCK: begin
        if (sts.gap_ok) st_nxt = S_INS_RD;
        else if (sts.idx_last) st_nxt = S_A_GROW;
        else st_nxt = S_A_SCRD;
      end
      S_A_GROW: st_nxt = sts.grow_ok ? S_INS_RD : S_DONE;
      S_INS_RD: st_nxt = sts.idx_at_pos ? S_INS_WR : S_INS_MV;
      S_INS_MV: st_nxt = S_INS_RD;
      S_INS_WR: st_nxt = (kind_r == K_MOVE) ? S_FIND_RD : S_DONE;
      S_FIND_RD: st_nxt = sts.idx_at_cnt ? S_DONE : S_FIND_CK;
      S_FIND_CK: st_nxt = sts.match ? S_HIT : S_FIND_RD;
      S_HIT: begin
        if (kind_r != K_RESIZE) st_nxt = S_REM_RD;
        else if (sts.shrink_ok || sts.idx_last) st_nxt = S_DONE;
        else st_nxt = S_RS_NXCK;
      end
      S_RS_NXCK: begin
        if (sts.next_ok) begin
          st_nxt = S_DONE;
        end else begin
          kind_nxt = K_MOVE;
          st_nxt   = S_A_CHK;
        end
      end
      S_REM_RD: st_nxt = sts.idx_at_cnt ? S_DONE : S_REM_MV;
      S_REM_MV: st_nxt = S_REM_RD;
      S_DONE: begin
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Outputs: datapath commands and input handshake
  always_comb begin
    cmd      = '0;
    cmd.ra   = RA_IDX;
    cmd.wa   = WA_IDX;
    cmd.wd   = WD_RDQ;
    cmd.ix   = IX_HOLD;
    cmd.ins  = INS_HOLD;
    cmd.top  = TOP_HOLD;
    cmd.res  = RES_HOLD;
    in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          cmd.res   = RES_CLR;
          cmd.ix    = IX_ZERO;
        end
      end
      S_A_CHK: begin
        if (sts.cnt_full) cmd.res = RES_CLR;
        else if (!sts.cnt_zero) cmd.rd = 1'b1;
      end
      S_A_FIRST: begin
        if (sts.first_ok) begin
          cmd.ins = INS_BASE;
          cmd.ix  = IX_COUNT;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.ix      = IX_ONE;
        end
      end
      S_A_SCRD: cmd.rd = 1'b1;
      S_A_SCCK: begin
        if (sts.gap_ok) begin
          cmd.ins = INS_GAP;
          cmd.ix  = IX_COUNT;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.ix      = IX_INC;
        end
      end
      S_A_GROW: begin
        if (sts.grow_ok) begin
          cmd.ins = INS_TOP;
          cmd.top = TOP_GROW;
          cmd.ix  = IX_COUNT;
        end else begin
          cmd.res = RES_CLR;
        end
      end
      S_INS_RD: begin
        if (!sts.idx_at_pos) begin
          cmd.rd = 1'b1;
          cmd.ra = RA_DEC;
        end
      end
      S_INS_MV: begin
        cmd.wr = 1'b1;
        cmd.ix = IX_DEC;
      end
      S_INS_WR: begin
        cmd.wr      = 1'b1;
        cmd.wa      = WA_POS;
        cmd.wd      = WD_NEW;
        cmd.cnt_inc = 1'b1;
        cmd.res     = RES_ALLOC;
        if (kind_r == K_MOVE) cmd.ix = IX_ZERO;
      end
      S_FIND_RD: begin
        if (sts.idx_at_cnt) cmd.res = RES_CLR;
        else cmd.rd = 1'b1;
      end
      S_FIND_CK: begin
        if (sts.match) begin
          cmd.cur_ld = 1'b1;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.ix      = IX_INC;
        end
      end
      S_HIT: begin
        if (kind_r != K_RESIZE) begin
          if (sts.cnt_one) cmd.top = TOP_CUR;
          else if (sts.idx_last) cmd.top = TOP_PREV;
          cmd.ix  = IX_INC;
          cmd.res = (kind_r == K_MOVE) ? RES_MOVE : RES_FREE;
        end else if (sts.shrink_ok || (sts.idx_last && sts.last_ok)) begin
          cmd.wr  = 1'b1;
          cmd.wd  = WD_RESIZE;
          cmd.res = RES_INPLACE;
          if (sts.idx_last) cmd.top = TOP_RESIZE;
        end else if (!sts.idx_last) begin
          cmd.rd = 1'b1;
          cmd.ra = RA_INC;
        end
      end
      S_RS_NXCK: begin
        if (sts.next_ok) begin
          cmd.wr  = 1'b1;
          cmd.wd  = WD_RESIZE;
          cmd.res = RES_INPLACE;
        end else begin
          cmd.res = RES_SAVECP;
          cmd.ix  = IX_ZERO;
        end
      end
      S_REM_RD: begin
        if (sts.idx_at_cnt) cmd.cnt_dec = 1'b1;
        else cmd.rd = 1'b1;
      end
      S_REM_MV: begin
        cmd.wr = 1'b1;
        cmd.wa = WA_DEC;
        cmd.ix = IX_INC;
      end
      default: ;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == S_DISP)
    else $error("accepted request not dispatched");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_DONE))
    else $error("result raised outside completion");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> st_r != S_IDLE && !in_ready)
    else $error("table write while idle");

endmodule

// File: design/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Channel   | Ports        | Direction | Moves
// ----------+--------------+-----------+----------------------------------------
// request   | in_req.*     | sink      | operation, block_address, request_size
// result    | out_rsp.*    | source    | result_address, success, must_copy, ...
// config    | cfg_wr.*     | sink      | index, data (always ready)
//
// One request at a time. Each table entry visited takes a memory read, then a
// check or a shifted write. Reset clears the count, heap base and heap top and
// sets the heap limit to 65536; the table needs no clearing.
// The result register holds until taken; the next request is accepted in the
// same cycle the result leaves.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  ffa_req_if.sink          in_req,
  ffa_rsp_if.source        out_rsp,
  ffa_cfg_if.sink          cfg_wr
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_wr.ready = 1'b1;

  // Sequence the request
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table, heap state and arithmetic
  ffa_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_req.operation),
    .in_block_address (in_req.block_address),
    .in_request_size  (in_req.request_size),
    .cfg_valid        (cfg_wr.valid),
    .cfg_index        (cfg_wr.index),
    .cfg_data         (cfg_wr.data),
    .result_address   (out_rsp.result_address),
    .success          (out_rsp.success),
    .must_copy        (out_rsp.must_copy),
    .copy_length      (out_rsp.copy_length)
  );

endmodule

// File: bench/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
  import ffa_pkg::*;

  localparam int        SLOTS       = 64;
  localparam int        HDR         = 16;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int        STALL_LIMIT = 20000;

  typedef struct {
    logic [31:0] addr;
    logic        ok;
    logic        moved;
    logic [31:0] copy_len;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();
  ffa_cfg_if cfg_ch ();

  first_fit_block_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .cfg_wr (cfg_ch)
  );

  // Shadow allocator state
  logic [63:0] blk_start [SLOTS];
  logic [63:0] blk_pay   [SLOTS];
  int          live_cnt;
  logic [63:0] top_addr, base_addr, limit_addr;

  grant_t pending_grants[$];
  bit     calm;
  bit     failed;
  int     stall_cycles;

  always #5 clk = ~clk;

  function automatic logic [63:0] padded_bytes(input logic [63:0] req);
    return (req + HDR + 7) & ~64'd7;
  endfunction

  function automatic logic [63:0] end_of(input int i);
    return blk_start[i] + HDR + blk_pay[i];
  endfunction

  function automatic int lookup_block(input logic [63:0] addr);
    for (int i = 0; i < live_cnt; i++)
      if (blk_start[i] + HDR == addr) return i;
    return -1;
  endfunction

  function automatic void link_block(input int pos, input logic [63:0] start,
                                     input logic [63:0] size);
    for (int i = live_cnt; i > pos; i--) begin
      blk_start[i] = blk_start[i-1];
      blk_pay[i]   = blk_pay[i-1];
    end
    blk_start[pos] = start;
    blk_pay[pos]   = size - HDR;
    live_cnt++;
  endfunction

  function automatic void unlink_block(input int pos);
    for (int i = pos; i < live_cnt - 1; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_pay[i]   = blk_pay[i+1];
    end
    live_cnt--;
  endfunction

  function automatic bit place_block(input logic [63:0] req, output logic [63:0] addr);
    logic [63:0] size, gap_top;
    size = padded_bytes(req);
    addr = 0;
    if (live_cnt >= SLOTS) return 0;
    if (live_cnt > 0 && base_addr + size < blk_start[0]) begin
      link_block(0, base_addr, size);
      addr = base_addr + HDR;
      return 1;
    end
    for (int i = 0; i + 1 < live_cnt; i++) begin
      gap_top = end_of(i);
      if (blk_start[i+1] >= gap_top && blk_start[i+1] - gap_top >= size) begin
        link_block(i + 1, gap_top, size);
        addr = gap_top + HDR;
        return 1;
      end
    end
    if (top_addr + size > limit_addr) return 0;
    link_block(live_cnt, top_addr, size);
    addr = top_addr + HDR;
    top_addr = top_addr + size;
    return 1;
  endfunction

  function automatic bit release_block(input logic [63:0] addr);
    int k;
    if (addr == 0 || live_cnt == 0) return 0;
    k = lookup_block(addr);
    if (k < 0) return 0;
    if (live_cnt == 1) top_addr = blk_start[0];
    else if (k + 1 == live_cnt) top_addr = end_of(k - 1);
    unlink_block(k);
    return 1;
  endfunction

  // Work out the grant for one request and update the shadow state
  function automatic grant_t predict_grant(input logic [1:0] op, input logic [31:0] addr_in,
                                           input logic [31:0] size_in);
    grant_t      g;
    logic [63:0] addr, req, res, size, old_len;
    int          k;
    bit          last;
    addr = {32'd0, addr_in};
    req  = {32'd0, size_in};
    res  = 0;
    g.ok = 0; g.moved = 0; g.copy_len = 0;
    if (op == OP_ALLOC) begin
      g.ok = place_block(req, res);
    end else if (op == OP_FREE) begin
      g.ok = release_block(addr);
    end else if (op == OP_RESIZE) begin
      if (addr != 0 && req == 0) begin
        g.ok = release_block(addr);
      end else if (addr == 0) begin
        g.ok = place_block(req, res);
      end else begin
        k = lookup_block(addr);
        if (k >= 0) begin
          size = padded_bytes(req);
          last = (k + 1 == live_cnt);
          if (blk_pay[k] + HDR >= size) begin
            blk_pay[k] = size - HDR;
            if (last) top_addr = blk_start[k] + size;
            res = addr;
            g.ok = 1;
          end else if (last) begin
            if (blk_start[k] + size <= limit_addr) begin
              blk_pay[k] = size - HDR;
              top_addr = blk_start[k] + size;
              res = addr;
              g.ok = 1;
            end
          end else if (blk_start[k+1] - blk_start[k] > size) begin
            blk_pay[k] = size - HDR;
            res = addr;
            g.ok = 1;
          end else begin
            old_len = blk_pay[k];
            if (place_block(req, res)) begin
              void'(release_block(addr));
              g.copy_len = old_len[31:0];
              g.moved = 1;
              g.ok = 1;
            end else begin
              res = 0;
            end
          end
        end
      end
    end
    g.addr = res[31:0];
    return g;
  endfunction

  // Send one request and record its expected grant on acceptance
  task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                              input logic [31:0] size);
    if (!calm && $urandom_range(99) < 26) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.operation     = op;
    req_ch.block_address = addr;
    req_ch.request_size  = size;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    pending_grants.push_back(predict_grant(op, addr, size));
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_HEAP_BASE) begin
      base_addr = {32'd0, value};
      if (live_cnt == 0) top_addr = base_addr;
    end else if (idx == REG_HEAP_LIMIT) begin
      limit_addr = {32'd0, value};
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] live_payload();
    if (live_cnt == 0) return 32'd0;
    return 32'(blk_start[$urandom_range(live_cnt - 1)] + HDR);
  endfunction

  task automatic release_all();
    while (live_cnt > 0) send_request(OP_FREE, live_payload(), 32'd0);
  endtask

  // Extremes, every operation and the named corner cases
  task automatic test_directed();
    logic [31:0] a;
    send_request(OP_FREE, 32'd0, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd0, 32'd1);
    send_request(OP_ALLOC, 32'd0, 32'd40);
    send_request(OP_RESIZE, 32'd0, 32'd24);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_RESIZE, 32'hAAAA_5555, 32'd8);
    a = 32'(blk_start[0] + HDR);
    send_request(OP_RESIZE, a, 32'd300);
    send_request(OP_ALLOC, 32'd0, 32'd4);
    a = 32'(blk_start[live_cnt-1] + HDR);
    send_request(OP_RESIZE, a, 32'd2);
    send_request(OP_RESIZE, a, 32'd500);
    send_request(OP_RESIZE, a, 32'd70000);
    a = 32'(blk_start[1] + HDR);
    send_request(OP_RESIZE, a, 32'd1);
    send_request(OP_RESIZE, a, 32'd4);
    send_request(OP_FREE, a, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd2);
    send_request(OP_UNUSED, 32'h5555_AAAA, 32'h1234_5678);
    send_request(OP_RESIZE, 32'(blk_start[live_cnt-1] + HDR), 32'd0);
    send_request(OP_FREE, 32'(blk_start[live_cnt-1] + HDR), 32'd0);
    release_all();
    send_request(OP_ALLOC, 32'd0, 32'd16);
    wait_drained();
  endtask

  // Fill the table, fail both an allocate and a forced move, then free one block so the same move succeeds
  task automatic test_full_table();
    repeat (SLOTS + 1) send_request(OP_ALLOC, 32'd0, $urandom_range(0, 24));
    send_request(OP_RESIZE, 32'(blk_start[0] + HDR), 32'd400);
    send_request(OP_FREE, 32'(blk_start[5] + HDR), 32'd0);
    send_request(OP_RESIZE, 32'(blk_start[0] + HDR), 32'd400);
    release_all();
    wait_drained();
  endtask

  // Register extremes: top of the address space, zero limit, moved base
  task automatic test_config_extremes();
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    send_request(OP_ALLOC, 32'd0, 32'd100);
    send_request(OP_ALLOC, 32'd0, 32'd200);
    send_request(OP_RESIZE, 32'(blk_start[0] + HDR), 32'd50);
    wait_drained();
    write_reg(REG_HEAP_BASE, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd8);
    release_all();
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'd0);
    write_reg(REG_HEAP_BASE, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFE0);
    send_request(OP_ALLOC, 32'd0, 32'd8);
    release_all();
    wait_drained();
  endtask

  // Random mix of operations over several heap settings
  task automatic test_random();
    int          pick;
    logic [31:0] a, s;
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      wait_drained();
      if (live_cnt == 0) write_reg(REG_HEAP_BASE, $urandom() & 32'hFFF0_0000);
      write_reg(REG_HEAP_LIMIT, 32'(base_addr) + $urandom_range(512, 65536));
      repeat (75) begin
        pick = $urandom_range(99);
        s = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(0, 300);
        a = ($urandom_range(9) == 0) ? $urandom() : live_payload();
        if (pick < 42) send_request(OP_ALLOC, 32'd0, s);
        else if (pick < 70) send_request(OP_FREE, a, 32'd0);
        else if (pick < 95) send_request(OP_RESIZE, a, s);
        else send_request(OP_UNUSED, $urandom(), $urandom());
      end
    end
    calm = 0;
    wait_drained();
  endtask

  // Result readiness with random back-pressure
  always @(negedge clk)
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

  // Compare each grant against the oldest expectation
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result address=%h", rsp_ch.result_address);
        failed = 1;
      end else begin
        g = pending_grants.pop_front();
        if (rsp_ch.result_address !== g.addr) begin
          $error("result_address expected %h actual %h", g.addr, rsp_ch.result_address);
          failed = 1;
        end
        if (rsp_ch.success !== g.ok) begin
          $error("success expected %b actual %b", g.ok, rsp_ch.success);
          failed = 1;
        end
        if (rsp_ch.must_copy !== g.moved) begin
          $error("must_copy expected %b actual %b", g.moved, rsp_ch.must_copy);
          failed = 1;
        end
        if (rsp_ch.copy_length !== g.copy_len) begin
          $error("copy_length expected %h actual %h", g.copy_len, rsp_ch.copy_length);
          failed = 1;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("first_fit_block_allocator test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.block_address = 32'd0;
    req_ch.request_size = 32'd0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_HEAP_BASE;
    cfg_ch.data = 32'd0;
    calm = 0;
    failed = 0;
    stall_cycles = 0;
    live_cnt = 0;
    base_addr = 0;
    limit_addr = 64'd65536;
    top_addr = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_full_table();
    test_config_extremes();
    test_random();
    repeat (300) @(negedge clk);
    if (!failed && pending_grants.size() == 0) begin
      $display("first_fit_block_allocator test passed");
    end else begin
      $display("first_fit_block_allocator test failed");
    end
    $finish;
  end

endmodule
